### sv/mcsg_pkg.sv
// shared types, codes and constants for the motion command safety gate
`default_nettype none

package mcsg_pkg;

   // sizes
   localparam int unsigned NUM_JOINTS     = 6;
   localparam int unsigned NUM_SOURCES    = 8;
   localparam int unsigned SRC_SLOTS      = 8;
   localparam int unsigned SRC_W          = 3;
   localparam int unsigned TS_W           = 32;
   localparam int unsigned CNT_W          = 32;
   localparam int unsigned DEADTIME_W     = 16;
   localparam logic [DEADTIME_W-1:0] DEADTIME_RESET = 16'd100;
   localparam logic signed [15:0] ANGLE_MAX_TENTHS = 16'sd1800;
   localparam int unsigned REQ_DATA_W     = 72;
   localparam int unsigned RSP_DATA_W     = 136;

   // item kinds carried in tuser
   localparam logic OP_VALIDATE  = 1'b0;
   localparam logic OP_SET_STATE = 1'b1;

   // motion types
   localparam logic [2:0] MT_NONE   = 3'd0;
   localparam logic [2:0] MT_ESTOP  = 3'd1;
   localparam logic [2:0] MT_HOME   = 3'd2;
   localparam logic [2:0] MT_SERVO  = 3'd3;

   // system states (value 7 can be stored and forbids all but emergency stop)
   localparam logic [2:0] SS_INIT   = 3'd0;
   localparam logic [2:0] SS_IDLE   = 3'd1;
   localparam logic [2:0] SS_ACTIVE = 3'd2;
   localparam logic [2:0] SS_CALIB  = 3'd3;
   localparam logic [2:0] SS_ERROR  = 3'd4;
   localparam logic [2:0] SS_SAFE   = 3'd5;
   localparam logic [2:0] SS_ESTOP  = 3'd6;

   // operator sources
   localparam logic [SRC_W-1:0] SRC_CLI   = 3'd0;
   localparam logic [SRC_W-1:0] SRC_PANEL = 3'd1;

   typedef enum logic [1:0] {
      REJ_NONE     = 2'd0,
      REJ_LIMIT    = 2'd1,
      REJ_STATE    = 2'd2,
      REJ_DEADTIME = 2'd3
   } reject_code_type;

   typedef struct packed {
      logic              op;
      logic [2:0]        motion_type;
      logic [SRC_W-1:0]  command_source;
      logic              is_critical;
      logic [7:0]        target_joint;
      logic signed [15:0] target_angle_tenths;
      logic [TS_W-1:0]   timestamp_ms;
      logic [2:0]        new_system_state;
   } item_type;

   typedef struct packed {
      logic            accepted;
      reject_code_type code;
      logic            stamp;
   } verdict_type;

endpackage

`default_nettype wire

### sv/motion_command_safety_gate_core.sv
// top level: command/state words in, one verdict word out per input word
// path: req accept loads the check stage register and the timestamp read, then the verdict goes to the output register
// throughput: one word per cycle while rsp does not stall
// stalls on rsp hold the check stage; an output register parts the two sides
// reset: synchronous, active high; clears state, counters, valid bits, dead time to 100
`default_nettype none

module motion_command_safety_gate_core #(
   parameter int unsigned NUM_JOINTS  = mcsg_pkg::NUM_JOINTS,
   parameter int unsigned NUM_SOURCES = mcsg_pkg::NUM_SOURCES
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // fields from bit 0: motion_type[2:0], command_source[5:3], is_critical[6],
   // target_joint[14:7], target_angle_tenths[30:15], timestamp_ms[62:31],
   // new_system_state[65:63], zero fill
   input  wire logic [mcsg_pkg::REQ_DATA_W-1:0]    req_tdata,
   // op[0]
   input  wire logic                               req_tuser,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // fields from bit 0: accepted[0], reject_code[2:1], accepted_count[34:3],
   // state_reject_count[66:35], limit_reject_count[98:67],
   // deadtime_reject_count[130:99], zero fill
   output logic [mcsg_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   input  wire logic [mcsg_pkg::DEADTIME_W-1:0]    csr_data,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready
);

   mcsg_pkg::item_type    req_item;
   mcsg_pkg::item_type    s1_item_ff;
   mcsg_pkg::verdict_type verdict;
   logic                  s1_valid_ff;
   logic                  s1_adv;
   logic                  req_take;
   logic [mcsg_pkg::TS_W-1:0] last_time;
   logic                  last_valid;
   logic [2:0]            system_state_ff;
   logic [mcsg_pkg::DEADTIME_W-1:0] deadtime_ff;
   logic [mcsg_pkg::CNT_W-1:0] acc_cnt_ff, state_cnt_ff, limit_cnt_ff, dead_cnt_ff;
   logic [mcsg_pkg::CNT_W-1:0] acc_cnt_in, state_cnt_in, limit_cnt_in, dead_cnt_in;
   logic                  rsp_valid_ff;
   logic [mcsg_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   // unpack the request word
   assign req_item.op                  = req_tuser;
   assign req_item.motion_type         = req_tdata[2:0];
   assign req_item.command_source      = req_tdata[5:3];
   assign req_item.is_critical         = req_tdata[6];
   assign req_item.target_joint        = req_tdata[14:7];
   assign req_item.target_angle_tenths = req_tdata[30:15];
   assign req_item.timestamp_ms        = req_tdata[62:31];
   assign req_item.new_system_state    = req_tdata[65:63];

   // handshake
   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // timestamp memory, read on accept, written as an accepted command retires
   mcsg_ts_mem u_ts_mem (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_take),
      .rd_addr  (req_item.command_source),
      .wr_en    (s1_adv && verdict.stamp),
      .wr_addr  (s1_item_ff.command_source),
      .wr_data  (s1_item_ff.timestamp_ms),
      .rd_data  (last_time),
      .rd_valid (last_valid)
   );

   // check stage decision
   mcsg_check #(
      .NUM_JOINTS   (NUM_JOINTS),
      .NUM_SOURCES  (NUM_SOURCES)
   ) u_check (
      .item         (s1_item_ff),
      .system_state (system_state_ff),
      .last_time    (last_time),
      .last_valid   (last_valid),
      .deadtime_ms  (deadtime_ff),
      .verdict      (verdict)
   );

   // next counter values
   always_comb begin
      acc_cnt_in   = acc_cnt_ff;
      state_cnt_in = state_cnt_ff;
      limit_cnt_in = limit_cnt_ff;
      dead_cnt_in  = dead_cnt_ff;
      if (s1_item_ff.op == mcsg_pkg::OP_VALIDATE) begin
         if (verdict.accepted) begin
            acc_cnt_in = acc_cnt_ff + 1'b1;
         end else begin
            case (verdict.code)
               mcsg_pkg::REJ_STATE:    state_cnt_in = state_cnt_ff + 1'b1;
               mcsg_pkg::REJ_LIMIT:    limit_cnt_in = limit_cnt_ff + 1'b1;
               mcsg_pkg::REJ_DEADTIME: dead_cnt_in  = dead_cnt_ff + 1'b1;
               default: begin
               end
            endcase
         end
      end
   end

   // check stage register
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff <= req_item;
      end
   end

   // control state, counters and dead time register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         system_state_ff <= mcsg_pkg::SS_INIT;
         deadtime_ff     <= mcsg_pkg::DEADTIME_RESET;
         acc_cnt_ff      <= '0;
         state_cnt_ff    <= '0;
         limit_cnt_ff    <= '0;
         dead_cnt_ff     <= '0;
      end else begin
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (s1_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            deadtime_ff <= csr_data;
         end
         if (s1_adv) begin
            if (s1_item_ff.op == mcsg_pkg::OP_SET_STATE) begin
               system_state_ff <= s1_item_ff.new_system_state;
            end
            acc_cnt_ff   <= acc_cnt_in;
            state_cnt_ff <= state_cnt_in;
            limit_cnt_ff <= limit_cnt_in;
            dead_cnt_ff  <= dead_cnt_in;
         end
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_data_ff <= {5'd0, dead_cnt_in, limit_cnt_in, state_cnt_in, acc_cnt_in,
                         verdict.code, verdict.accepted};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

### sv/mcsg_ts_mem.sv
// per-source timestamp memory with valid bits and write-to-read forwarding
`default_nettype none

module mcsg_ts_mem (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          rd_en,
   input  wire logic [mcsg_pkg::SRC_W-1:0]    rd_addr,
   input  wire logic                          wr_en,
   input  wire logic [mcsg_pkg::SRC_W-1:0]    wr_addr,
   input  wire logic [mcsg_pkg::TS_W-1:0]     wr_data,
   output logic [mcsg_pkg::TS_W-1:0]          rd_data,
   output logic                               rd_valid
);

   logic [mcsg_pkg::TS_W-1:0] mem [mcsg_pkg::SRC_SLOTS];
   logic [mcsg_pkg::SRC_SLOTS-1:0] valid_ff;
   logic [mcsg_pkg::TS_W-1:0] rd_data_ff;
   logic rd_valid_ff;
   logic collide;

   // a write to the entry being read in the same cycle is forwarded
   assign collide = wr_en && (wr_addr == rd_addr);

   // storage array
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= collide ? wr_data : mem[rd_addr];
      end
   end

   // entry valid bits, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= collide || valid_ff[rd_addr];
         end
      end
   end

   assign rd_data  = rd_data_ff;
   assign rd_valid = rd_valid_ff;

endmodule

`default_nettype wire

### sv/mcsg_check.sv
// command checks: type, system state, servo limits and dead time
`default_nettype none

module mcsg_check #(
   parameter int unsigned NUM_JOINTS  = mcsg_pkg::NUM_JOINTS,
   parameter int unsigned NUM_SOURCES = mcsg_pkg::NUM_SOURCES
) (
   input  wire mcsg_pkg::item_type                 item,
   input  wire logic [2:0]                         system_state,
   input  wire logic [mcsg_pkg::TS_W-1:0]          last_time,
   input  wire logic                               last_valid,
   input  wire logic [mcsg_pkg::DEADTIME_W-1:0]    deadtime_ms,
   output mcsg_pkg::verdict_type                   verdict
);

   logic operator_src;
   logic state_ok;
   logic limits_ok;
   logic in_slots;
   logic deadtime_ok;
   logic [mcsg_pkg::TS_W-1:0] elapsed;

   assign operator_src = (item.command_source == mcsg_pkg::SRC_CLI)
                      || (item.command_source == mcsg_pkg::SRC_PANEL);

   // state check
   always_comb begin
      state_ok = 1'b0;
      if (item.motion_type == mcsg_pkg::MT_ESTOP) begin
         state_ok = 1'b1;
      end else begin
         case (system_state)
            mcsg_pkg::SS_INIT: begin
               state_ok = (item.motion_type == mcsg_pkg::MT_HOME);
            end
            mcsg_pkg::SS_IDLE, mcsg_pkg::SS_ACTIVE: begin
               state_ok = 1'b1;
            end
            mcsg_pkg::SS_CALIB, mcsg_pkg::SS_ERROR: begin
               state_ok = operator_src;
            end
            mcsg_pkg::SS_SAFE: begin
               state_ok = (item.motion_type == mcsg_pkg::MT_HOME) && operator_src;
            end
            default: begin
               state_ok = 1'b0;
            end
         endcase
      end
   end

   // servo joint and angle limits
   assign limits_ok = (item.motion_type != mcsg_pkg::MT_SERVO)
                   || ((item.target_joint < 8'(NUM_JOINTS))
                       && (item.target_angle_tenths >= 16'sd0)
                       && (item.target_angle_tenths <= mcsg_pkg::ANGLE_MAX_TENTHS));

   // dead time since the source's last accepted command
   assign in_slots    = ({1'b0, item.command_source} < 4'(NUM_SOURCES));
   assign elapsed     = item.timestamp_ms - last_time;
   assign deadtime_ok = item.is_critical || !in_slots || !last_valid
                     || (last_time == '0)
                     || (elapsed >= {{(mcsg_pkg::TS_W-mcsg_pkg::DEADTIME_W){1'b0}},
                                     deadtime_ms});

   // verdict in check order
   always_comb begin
      verdict.accepted = 1'b0;
      verdict.code     = mcsg_pkg::REJ_NONE;
      verdict.stamp    = 1'b0;
      if (item.op == mcsg_pkg::OP_VALIDATE) begin
         if (item.motion_type == mcsg_pkg::MT_NONE) begin
            verdict.code = mcsg_pkg::REJ_LIMIT;
         end else if (!state_ok) begin
            verdict.code = mcsg_pkg::REJ_STATE;
         end else if (!limits_ok) begin
            verdict.code = mcsg_pkg::REJ_LIMIT;
         end else if (!deadtime_ok) begin
            verdict.code = mcsg_pkg::REJ_DEADTIME;
         end else begin
            verdict.accepted = 1'b1;
            verdict.stamp    = in_slots;
         end
      end
   end

endmodule

`default_nettype wire

### bench/tb.sv
// testbench for the motion command safety gate: directed table, then random words
`timescale 1ns / 1ps

module tb;

   // motion types and states that the package leaves unnamed
   localparam logic [2:0] MT_MOVE_A = 3'd4;
   localparam logic [2:0] MT_MOVE_B = 3'd5;
   localparam logic [2:0] MT_MOVE_C = 3'd6;
   localparam logic [2:0] MT_MOVE_D = 3'd7;
   localparam logic [2:0] SS_UNDEF  = 3'd7;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int WORDS_PER_PHASE = 150;
   localparam int NUM_PHASES = 5;
   localparam int NUM_DIRECTED = 29;

   // one verdict word as seen on rsp_tdata
   typedef struct packed {
      logic                      accepted;
      mcsg_pkg::reject_code_type code;
      logic [31:0]               accepts;
      logic [31:0]               state_rej;
      logic [31:0]               limit_rej;
      logic [31:0]               dead_rej;
   } exp_verdict_type;

   // directed row: kind is the motion type, or the new state for a state word
   typedef struct packed {
      logic                      op;
      logic [2:0]                kind;
      logic [2:0]                src;
      logic                      crit;
      logic [7:0]                joint;
      logic signed [15:0]        angle;
      logic [31:0]               stamp;
      logic                      pinned;
      logic                      want_acc;
      mcsg_pkg::reject_code_type want_code;
   } drow_type;

   // dead time is 100 at reset and the gate starts in init
   localparam drow_type DIRECTED [NUM_DIRECTED] = '{
      '{mcsg_pkg::OP_VALIDATE, mcsg_pkg::MT_NONE, 3'd0, 1'b0, 8'd0, 16'sd0, 32'd5,
        1'b1, 1'b0, mcsg_pkg::REJ_LIMIT},
      '{mcsg_pkg::OP_VALIDATE, mcsg_pkg::MT_SERVO, 3'd0, 1'b0, 8'd0, 16'sd900, 32'd10,
        1'b1, 1'b0, mcsg_pkg::REJ_STATE},
      '{mcsg_pkg::OP_VALIDATE, mcsg_pkg::MT_HOME, 3'd7, 1'b0, 8'd0, 16'sd0, 32'd1000,
        1'b1, 1'b1, mcsg_pkg::REJ_NONE},
      '{mcsg_pkg::OP_VALIDATE, mcsg_pkg::MT_ESTOP, 3'd7, 1'b0, 8'd0, 16'sd0, 32'd1050,
        1'b1, 1'b0, mcsg_pkg::REJ_DEADTIME},
      '{mcsg_pkg::OP_VALIDATE, mcsg_pkg::MT_ESTOP, 3'd7, 1'b1, 8'd0, 16'sd0, 32'd1050,
        1'b1, 1'b1, mcsg_pkg::REJ_NONE},
      '{mcsg_pkg::OP_SET_STATE, mcsg_pkg::SS_IDLE, 3'd0, 1'b0, 8'd0, 16'sd0, 32'd0,
        1'b1, 1'b0, mcsg_pkg::REJ_NONE},
      '{mcsg_pkg::OP_VALIDATE, mcsg_pkg::MT_SERVO, 3'd2, 1'b0, 8'd5, 16'sd0, 32'hFFFF_FFFF,
        1'b1, 1'b1, mcsg_pkg::REJ_NONE},
      '{mcsg_pkg::OP_VALIDATE, mcsg_pkg::MT_SERVO, 3'd3, 1'b0, 8'd6, 16'sd900, 32'd20,
        1'b1, 1'b0, mcsg_pkg::REJ_LIMIT},
      '{mcsg_pkg::OP_VALIDATE, mcsg_pkg::MT_SERVO, 3'd3, 1'b0, 8'd0, 16'sd1800, 32'd7,
        1'b1, 1'b1, mcsg_pkg::REJ_NONE},
      '{mcsg_pkg::OP_VALIDATE, mcsg_pkg::MT_SERVO, 3'd4, 1'b1, 8'd0, 16'sd1801, 32'd30,
        1'b1, 1'b0, mcsg_pkg::REJ_LIMIT},
      '{mcsg_pkg::OP_VALIDATE, mcsg_pkg::MT_SERVO, 3'd4, 1'b1, 8'd0, -16'sd1, 32'd30,
        1'b1, 1'b0, mcsg_pkg::REJ_LIMIT},
      '{mcsg_pkg::OP_VALIDATE, mcsg_pkg::MT_SERVO, 3'd5, 1'b0, 8'd255, 16'sh8000,
        32'hFFFF_FFFF, 1'b1, 1'b0, mcsg_pkg::REJ_LIMIT},
      '{mcsg_pkg::OP_VALIDATE, mcsg_pkg::MT_SERVO, 3'd5, 1'b0, 8'd1, 16'sh7FFF, 32'd40,
        1'b1, 1'b0, mcsg_pkg::REJ_LIMIT},
      // stamp wraps: 98 is 99 ms after the all-ones stamp, one short
      '{mcsg_pkg::OP_VALIDATE, mcsg_pkg::MT_SERVO, 3'd2, 1'b0, 8'd2, 16'sd100, 32'd98,
        1'b1, 1'b0, mcsg_pkg::REJ_DEADTIME},
      '{mcsg_pkg::OP_VALIDATE, mcsg_pkg::MT_SERVO, 3'd2, 1'b0, 8'd2, 16'sd100, 32'd99,
        1'b0, 1'b0, mcsg_pkg::REJ_NONE},
      // accepted at stamp zero leaves the source as never sent
      '{mcsg_pkg::OP_VALIDATE, MT_MOVE_D, 3'd4, 1'b0, 8'd0, 16'sd0, 32'd0,
        1'b1, 1'b1, mcsg_pkg::REJ_NONE},
      '{mcsg_pkg::OP_VALIDATE, MT_MOVE_A, 3'd4, 1'b0, 8'd0, 16'sd0, 32'd1,
        1'b0, 1'b0, mcsg_pkg::REJ_NONE},
      '{mcsg_pkg::OP_SET_STATE, mcsg_pkg::SS_CALIB, 3'd0, 1'b0, 8'd0, 16'sd0, 32'd0,
        1'b1, 1'b0, mcsg_pkg::REJ_NONE},
      '{mcsg_pkg::OP_VALIDATE, mcsg_pkg::MT_HOME, 3'd5, 1'b1, 8'd0, 16'sd0, 32'd2000,
        1'b1, 1'b0, mcsg_pkg::REJ_STATE},
      '{mcsg_pkg::OP_VALIDATE, MT_MOVE_B, 3'd1, 1'b0, 8'd0, 16'sd0, 32'd5000,
        1'b0, 1'b0, mcsg_pkg::REJ_NONE},
      '{mcsg_pkg::OP_SET_STATE, mcsg_pkg::SS_SAFE, 3'd0, 1'b0, 8'd0, 16'sd0, 32'd0,
        1'b1, 1'b0, mcsg_pkg::REJ_NONE},
      '{mcsg_pkg::OP_VALIDATE, mcsg_pkg::MT_HOME, 3'd0, 1'b0, 8'd0, 16'sd0, 32'd9000,
        1'b0, 1'b0, mcsg_pkg::REJ_NONE},
      '{mcsg_pkg::OP_VALIDATE, mcsg_pkg::MT_SERVO, 3'd1, 1'b1, 8'd0, 16'sd0, 32'd9500,
        1'b1, 1'b0, mcsg_pkg::REJ_STATE},
      '{mcsg_pkg::OP_SET_STATE, mcsg_pkg::SS_ESTOP, 3'd0, 1'b0, 8'd0, 16'sd0, 32'd0,
        1'b1, 1'b0, mcsg_pkg::REJ_NONE},
      '{mcsg_pkg::OP_VALIDATE, mcsg_pkg::MT_HOME, 3'd0, 1'b1, 8'd0, 16'sd0, 32'd20000,
        1'b1, 1'b0, mcsg_pkg::REJ_STATE},
      '{mcsg_pkg::OP_VALIDATE, mcsg_pkg::MT_ESTOP, 3'd6, 1'b0, 8'd0, 16'sd0, 32'h8000_0000,
        1'b0, 1'b0, mcsg_pkg::REJ_NONE},
      '{mcsg_pkg::OP_SET_STATE, SS_UNDEF, 3'd0, 1'b0, 8'd0, 16'sd0, 32'd0,
        1'b1, 1'b0, mcsg_pkg::REJ_NONE},
      '{mcsg_pkg::OP_VALIDATE, MT_MOVE_C, 3'd0, 1'b1, 8'd0, 16'sd0, 32'd30000,
        1'b1, 1'b0, mcsg_pkg::REJ_STATE},
      '{mcsg_pkg::OP_SET_STATE, mcsg_pkg::SS_ACTIVE, 3'd0, 1'b0, 8'd0, 16'sd0, 32'd0,
        1'b1, 1'b0, mcsg_pkg::REJ_NONE}
   };

   // clock, reset and bus signals
   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic [mcsg_pkg::REQ_DATA_W-1:0]     req_tdata = '0;
   logic                                req_tuser = 1'b0;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [mcsg_pkg::RSP_DATA_W-1:0]     rsp_tdata;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [mcsg_pkg::DEADTIME_W-1:0]     csr_data = '0;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;

   // predicted gate state
   logic [2:0]                          gate_state = mcsg_pkg::SS_INIT;
   logic [mcsg_pkg::DEADTIME_W-1:0]     dead_ms = mcsg_pkg::DEADTIME_RESET;
   logic [31:0]                         last_stamp [mcsg_pkg::SRC_SLOTS] = '{default: '0};
   logic [31:0]                         accept_tally = '0;
   logic [31:0]                         state_tally = '0;
   logic [31:0]                         limit_tally = '0;
   logic [31:0]                         dead_tally = '0;

   exp_verdict_type          expected_verdicts [$];
   int                       fail_count = 0;
   int                       words_sent = 0;
   int                       verdicts_checked = 0;
   int                       burst_left = 0;
   int                       idle_cycles = 0;

   motion_command_safety_gate_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_data   (csr_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      $display("mismatch %s at verdict %0d: got %0h want %0h",
               what, verdicts_checked, got, want);
      fail_count++;
   endtask

   // state permission check, emergency stop always passes
   function automatic logic state_allows(input logic [2:0] mt, input logic [2:0] src);
      logic op_src;
      op_src = (src == mcsg_pkg::SRC_CLI) || (src == mcsg_pkg::SRC_PANEL);
      if (mt == mcsg_pkg::MT_ESTOP) return 1'b1;
      case (gate_state)
         mcsg_pkg::SS_INIT:                      return mt == mcsg_pkg::MT_HOME;
         mcsg_pkg::SS_IDLE, mcsg_pkg::SS_ACTIVE: return 1'b1;
         mcsg_pkg::SS_CALIB, mcsg_pkg::SS_ERROR: return op_src;
         mcsg_pkg::SS_SAFE:                      return (mt == mcsg_pkg::MT_HOME) && op_src;
         default:                                return 1'b0;
      endcase
   endfunction

   // verdict for one word, updating the predicted state
   function automatic exp_verdict_type gate_verdict(input mcsg_pkg::item_type it);
      exp_verdict_type v;
      logic [31:0]     since_last;
      v = '0;
      since_last = it.timestamp_ms - last_stamp[it.command_source];
      if (it.op == mcsg_pkg::OP_SET_STATE) begin
         gate_state = it.new_system_state;
      end else if (it.motion_type == mcsg_pkg::MT_NONE) begin
         limit_tally++;
         v.code = mcsg_pkg::REJ_LIMIT;
      end else if (!state_allows(it.motion_type, it.command_source)) begin
         state_tally++;
         v.code = mcsg_pkg::REJ_STATE;
      end else if (it.motion_type == mcsg_pkg::MT_SERVO &&
                   (it.target_joint >= mcsg_pkg::NUM_JOINTS ||
                    it.target_angle_tenths < 0 ||
                    it.target_angle_tenths > mcsg_pkg::ANGLE_MAX_TENTHS)) begin
         limit_tally++;
         v.code = mcsg_pkg::REJ_LIMIT;
      end else if (!it.is_critical && 32'(it.command_source) < mcsg_pkg::NUM_SOURCES &&
                   last_stamp[it.command_source] != 0 && since_last < 32'(dead_ms)) begin
         dead_tally++;
         v.code = mcsg_pkg::REJ_DEADTIME;
      end else begin
         if (32'(it.command_source) < mcsg_pkg::NUM_SOURCES)
            last_stamp[it.command_source] = it.timestamp_ms;
         accept_tally++;
         v.accepted = 1'b1;
      end
      v.accepts   = accept_tally;
      v.state_rej = state_tally;
      v.limit_rej = limit_tally;
      v.dead_rej  = dead_tally;
      return v;
   endfunction

   // present one word, predict on acceptance, then pace the bursts
   task automatic send_word(input mcsg_pkg::item_type it, input logic pinned,
                            input logic want_acc,
                            input mcsg_pkg::reject_code_type want_code);
      exp_verdict_type v;
      int              gap;
      req_tdata  <= {6'd0, it.new_system_state, it.timestamp_ms, it.target_angle_tenths,
                     it.target_joint, it.is_critical, it.command_source, it.motion_type};
      req_tuser  <= it.op;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      v = gate_verdict(it);
      if (pinned) begin
         v.accepted = want_acc;
         v.code = want_code;
      end
      expected_verdicts.push_back(v);
      words_sent++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // wait out every verdict plus the pipeline depth
   task automatic drain_gate();
      req_tvalid <= 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_dead_time(input logic [mcsg_pkg::DEADTIME_W-1:0] ms);
      csr_data  <= ms;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      dead_ms = ms;
   endtask

   // random word: mostly plausible commands near the dead-time edge, some noise
   function automatic mcsg_pkg::item_type random_word();
      mcsg_pkg::item_type it;
      int                 pick;
      logic [31:0]        offset;
      logic [95:0]        noise;
      noise = {$urandom, $urandom, $urandom};
      it = noise[$bits(mcsg_pkg::item_type)-1:0];
      pick = $urandom_range(0, 99);
      if (pick < 4) return it;
      it.op = mcsg_pkg::OP_VALIDATE;
      if (pick < 12) begin
         it.op = mcsg_pkg::OP_SET_STATE;
         if ($urandom_range(0, 9) < 7)
            it.new_system_state = $urandom_range(0, 1) ? mcsg_pkg::SS_IDLE
                                                       : mcsg_pkg::SS_ACTIVE;
         return it;
      end
      pick = $urandom_range(0, 99);
      if (pick < 5)       it.motion_type = mcsg_pkg::MT_NONE;
      else if (pick < 15) it.motion_type = mcsg_pkg::MT_ESTOP;
      else if (pick < 30) it.motion_type = mcsg_pkg::MT_HOME;
      else if (pick < 65) it.motion_type = mcsg_pkg::MT_SERVO;
      else                it.motion_type = MT_MOVE_A + 3'($urandom_range(0, 3));
      it.is_critical = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 85)
         it.target_joint = 8'($urandom_range(0, mcsg_pkg::NUM_JOINTS - 1));
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
         it.target_angle_tenths = 16'($urandom_range(0, 1800));
      end else if (pick < 90) begin
         case ($urandom_range(0, 3))
            0:       it.target_angle_tenths = -16'sd1;
            1:       it.target_angle_tenths = 16'sd0;
            2:       it.target_angle_tenths = mcsg_pkg::ANGLE_MAX_TENTHS;
            default: it.target_angle_tenths = mcsg_pkg::ANGLE_MAX_TENTHS + 16'sd1;
         endcase
      end
      // stamp relative to the source's last accepted one
      pick = $urandom_range(0, 99);
      if (pick < 30)      offset = 32'(dead_ms) - 32'd1;
      else if (pick < 50) offset = 32'(dead_ms);
      else if (pick < 90) offset = $urandom_range(0, 2 * dead_ms + 1);
      else                offset = $urandom;
      if (last_stamp[it.command_source] != 0)
         it.timestamp_ms = last_stamp[it.command_source] + offset;
      if ($urandom_range(0, 49) == 0) it.timestamp_ms = '0;
      return it;
   endfunction

   // receiver stalls on a rotating mask, renewed now and then
   logic [15:0] ready_mask = 16'hFFFF;
   int          mask_age = 0;
   always @(posedge clock) begin
      if (mask_age == 63) begin
         case ($urandom_range(0, 3))
            0:       ready_mask <= 16'hFFFF;
            1:       ready_mask <= 16'($urandom) | 16'h0001;
            default: ready_mask <= 16'($urandom) | 16'($urandom) | 16'h0001;
         endcase
         mask_age <= 0;
      end else begin
         ready_mask <= {ready_mask[14:0], ready_mask[15]};
         mask_age <= mask_age + 1;
      end
      rsp_tready <= ready_mask[0];
   end

   // compare each verdict word against the oldest prediction
   always @(posedge clock) begin : verdict_check
      exp_verdict_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_verdicts.size() == 0) begin
            flag_mismatch("unexpected word", 32'(rsp_tdata[2:0]), 32'd0);
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_tdata[0] !== want.accepted)
               flag_mismatch("accepted", 32'(rsp_tdata[0]), 32'(want.accepted));
            if (rsp_tdata[2:1] !== want.code)
               flag_mismatch("reject_code", 32'(rsp_tdata[2:1]), 32'(want.code));
            if (rsp_tdata[34:3] !== want.accepts)
               flag_mismatch("accepted_count", rsp_tdata[34:3], want.accepts);
            if (rsp_tdata[66:35] !== want.state_rej)
               flag_mismatch("state_reject_count", rsp_tdata[66:35], want.state_rej);
            if (rsp_tdata[98:67] !== want.limit_rej)
               flag_mismatch("limit_reject_count", rsp_tdata[98:67], want.limit_rej);
            if (rsp_tdata[130:99] !== want.dead_rej)
               flag_mismatch("deadtime_reject_count", rsp_tdata[130:99], want.dead_rej);
            verdicts_checked++;
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("tb NOT OK");
            $finish;
         end
      end
   end

   // stimulus
   initial begin : stimulus
      logic [mcsg_pkg::DEADTIME_W-1:0] dead_times [NUM_PHASES];
      mcsg_pkg::item_type              it;
      dead_times = '{16'hFFFF, 16'd0, 16'd1, 16'($urandom), mcsg_pkg::DEADTIME_RESET};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table at the reset dead time
      for (int r = 0; r < NUM_DIRECTED; r++) begin
         it = '0;
         it.op = DIRECTED[r].op;
         if (DIRECTED[r].op == mcsg_pkg::OP_SET_STATE) begin
            it.new_system_state = DIRECTED[r].kind;
         end else begin
            it.motion_type         = DIRECTED[r].kind;
            it.command_source      = DIRECTED[r].src;
            it.is_critical         = DIRECTED[r].crit;
            it.target_joint        = DIRECTED[r].joint;
            it.target_angle_tenths = DIRECTED[r].angle;
            it.timestamp_ms        = DIRECTED[r].stamp;
         end
         send_word(it, DIRECTED[r].pinned, DIRECTED[r].want_acc, DIRECTED[r].want_code);
      end

      // random phases, one dead-time value each
      for (int p = 0; p < NUM_PHASES; p++) begin
         drain_gate();
         set_dead_time(dead_times[p]);
         for (int n = 0; n < WORDS_PER_PHASE; n++)
            send_word(random_word(), 1'b0, 1'b0, mcsg_pkg::REJ_NONE);
      end

      drain_gate();
      repeat (8) @(posedge clock);
      if (expected_verdicts.size() != 0)
         flag_mismatch("verdicts left over", 32'(expected_verdicts.size()), 32'd0);
      $display("sent %0d words (%0d from the table), checked %0d verdicts",
               words_sent, NUM_DIRECTED, verdicts_checked);
      $display("dead times %0d/%0d/%0d/%0d/%0d; passed %0d, rejects %0d/%0d/%0d",
               dead_times[0], dead_times[1], dead_times[2], dead_times[3], dead_times[4],
               accept_tally, state_tally, limit_tally, dead_tally);
      if (fail_count == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule

### filelist.f
sv/mcsg_pkg.sv
sv/mcsg_ts_mem.sv
sv/mcsg_check.sv
sv/motion_command_safety_gate_core.sv
bench/tb.sv
